// ===== hw/rtl/dssm_pkg.sv =====
// Package: shared types and codes for the dual stack shared memory block.
`timescale 1ns / 1ps

package dssm_pkg;

    localparam int OP_W   = 2;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int CAP_W  = 9;
    localparam int CAP_RESET = 256;

    localparam logic [OP_W-1:0] OP_PUSH_ONE = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_TWO = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_ONE  = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_TWO  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_PUSHED   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STAT_POPPED   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } dssm_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // input word taken this cycle
        logic load_read;  // move registered read data into the output register
    } dssm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pop_hit;    // offered word is a pop from a non-empty stack
        logic out_full;   // output register holds a word not yet taken
    } dssm_stat_t;

endpackage

// ===== hw/rtl/dssm_req_if.sv =====
// Interface: request channel carrying one stack operation per word.
`timescale 1ns / 1ps

interface dssm_req_if;
    logic                          valid;
    logic                          ready;
    logic [dssm_pkg::OP_W-1:0]     operation;
    logic signed [dssm_pkg::DATA_W-1:0] push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);
endinterface

// ===== hw/rtl/dssm_rsp_if.sv =====
// Interface: response channel carrying one result word per operation.
`timescale 1ns / 1ps

interface dssm_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [dssm_pkg::DATA_W-1:0] popped_value;
    logic [dssm_pkg::STAT_W-1:0]        status;

    modport source (output valid, output popped_value, output status, input ready);
    modport sink   (input valid, input popped_value, input status, output ready);
endinterface

// ===== hw/rtl/dssm_ctrl.sv =====
// Controller: sequences accept, array read and output load.
`timescale 1ns / 1ps

module dssm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 rsp_ready,
    input  dssm_pkg::dssm_stat_t stat,
    output logic                 req_ready,
    output dssm_pkg::dssm_cmd_t  cmd
);

    dssm_pkg::dssm_state_t state_reg, state_next;
    logic                  slot_free;

    assign slot_free = !stat.out_full || rsp_ready;

    always_comb
    begin
        state_next    = state_reg;
        req_ready     = 1'b0;
        cmd.accept    = 1'b0;
        cmd.load_read = 1'b0;
        unique case (state_reg)
            dssm_pkg::S_IDLE:
            begin
                req_ready  = slot_free;
                cmd.accept = req_valid && slot_free;
                if (req_valid && slot_free && stat.pop_hit)
                begin
                    state_next = dssm_pkg::S_READ;
                end
            end
            dssm_pkg::S_READ:
            begin
                if (slot_free)
                begin
                    cmd.load_read = 1'b1;
                    state_next    = dssm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dssm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dssm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_read_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dssm_pkg::S_READ) |-> !req_ready)
        else $error("input taken while an array read is pending");

    a_pop_goes_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && stat.pop_hit) |=> (state_reg == dssm_pkg::S_READ))
        else $error("successful pop did not start a read");

endmodule

// ===== hw/rtl/dssm_datapath.sv =====
// Datapath: capacity register, stack pointers, shared array and output register.
`timescale 1ns / 1ps

module dssm_datapath #(
    parameter int MAX_DEPTH = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dssm_pkg::dssm_cmd_t                cmd,
    output dssm_pkg::dssm_stat_t               stat,
    input  logic [dssm_pkg::OP_W-1:0]          operation,
    input  logic signed [dssm_pkg::DATA_W-1:0] push_value,
    input  logic                               cfg_write,
    input  logic [dssm_pkg::CAP_W-1:0]         cfg_data,
    output logic [dssm_pkg::CAP_W-1:0]         capacity,
    input  logic                               rsp_ready,
    output logic                               rsp_valid,
    output logic signed [dssm_pkg::DATA_W-1:0] popped_value,
    output logic [dssm_pkg::STAT_W-1:0]        status
);

    localparam int PTR_W = $clog2(MAX_DEPTH + 1);
    localparam int AW    = $clog2(MAX_DEPTH);
    localparam int CAP_RST_I = (dssm_pkg::CAP_RESET > MAX_DEPTH) ? MAX_DEPTH
                                                                  : dssm_pkg::CAP_RESET;
    localparam logic [dssm_pkg::CAP_W-1:0] CAP_RST = dssm_pkg::CAP_W'(CAP_RST_I);

    logic [dssm_pkg::CAP_W-1:0]  capacity_reg;
    logic [dssm_pkg::CAP_W-1:0]  cap_clamped;
    logic [PTR_W-1:0]            lower_reg, lower_next;
    logic [PTR_W-1:0]            upper_reg, upper_next;
    logic [PTR_W-1:0]            cap_ptr;
    logic [PTR_W-1:0]            addr;
    logic                        full, lower_empty, upper_empty;
    logic                        mem_we;
    logic                        pop_hit;
    logic [dssm_pkg::STAT_W-1:0] dir_status;

    logic [dssm_pkg::DATA_W-1:0] mem [MAX_DEPTH];
    logic [dssm_pkg::DATA_W-1:0] rd_data_reg;

    logic                               out_valid_reg;
    logic signed [dssm_pkg::DATA_W-1:0] popped_reg;
    logic [dssm_pkg::STAT_W-1:0]        status_reg;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cap_clamped = dssm_pkg::CAP_W'(1);
        end
        else if (int'(cfg_data) > MAX_DEPTH)
        begin
            cap_clamped = dssm_pkg::CAP_W'(MAX_DEPTH);
        end
        else
        begin
            cap_clamped = cfg_data;
        end
    end

    // capacity never exceeds MAX_DEPTH, so it fits the pointer width
    assign cap_ptr     = PTR_W'(capacity_reg);
    assign full        = (lower_reg == upper_reg);
    assign lower_empty = (lower_reg == '0);
    assign upper_empty = (upper_reg == cap_ptr);

    always_comb
    begin
        lower_next = lower_reg;
        upper_next = upper_reg;
        addr       = lower_reg;
        mem_we     = 1'b0;
        dir_status = dssm_pkg::STAT_EMPTY;
        pop_hit    = 1'b0;
        case (operation)
            dssm_pkg::OP_PUSH_ONE:
            begin
                addr = lower_reg;
                if (full)
                begin
                    dir_status = dssm_pkg::STAT_OVERFLOW;
                end
                else
                begin
                    dir_status = dssm_pkg::STAT_PUSHED;
                    mem_we     = 1'b1;
                    lower_next = lower_reg + PTR_W'(1);
                end
            end
            dssm_pkg::OP_PUSH_TWO:
            begin
                addr = upper_reg - PTR_W'(1);
                if (full)
                begin
                    dir_status = dssm_pkg::STAT_OVERFLOW;
                end
                else
                begin
                    dir_status = dssm_pkg::STAT_PUSHED;
                    mem_we     = 1'b1;
                    upper_next = upper_reg - PTR_W'(1);
                end
            end
            dssm_pkg::OP_POP_ONE:
            begin
                addr = lower_reg - PTR_W'(1);
                if (!lower_empty)
                begin
                    pop_hit    = 1'b1;
                    lower_next = lower_reg - PTR_W'(1);
                end
            end
            default:
            begin
                addr = upper_reg;
                if (!upper_empty)
                begin
                    pop_hit    = 1'b1;
                    upper_next = upper_reg + PTR_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RST;
            lower_reg    <= '0;
            upper_reg    <= PTR_W'(CAP_RST);
        end
        else if (cfg_write)
        begin
            capacity_reg <= cap_clamped;
            lower_reg    <= '0;
            upper_reg    <= PTR_W'(cap_clamped);
        end
        else if (cmd.accept)
        begin
            lower_reg <= lower_next;
            upper_reg <= upper_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && mem_we)
        begin
            mem[addr[AW-1:0]] <= push_value;
        end
        if (cmd.accept && pop_hit)
        begin
            rd_data_reg <= mem[addr[AW-1:0]];
        end
    end

    // output register: pushes and empty pops load at accept, pops after the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.accept && !pop_hit) || cmd.load_read)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_read)
        begin
            popped_reg <= rd_data_reg;
            status_reg <= dssm_pkg::STAT_POPPED;
        end
        else if (cmd.accept && !pop_hit)
        begin
            popped_reg <= '0;
            status_reg <= dir_status;
        end
    end

    assign stat.pop_hit  = pop_hit;
    assign stat.out_full = out_valid_reg;
    assign rsp_valid     = out_valid_reg;
    assign popped_value  = popped_reg;
    assign status        = status_reg;
    assign capacity      = capacity_reg;

    a_ptr_order: assert property (@(posedge clk) disable iff (!rst_n)
        lower_reg <= upper_reg)
        else $error("stack pointers crossed");

    a_upper_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        upper_reg <= cap_ptr)
        else $error("stack two base above capacity");

    a_no_load_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.accept && cmd.load_read))
        else $error("direct and read loads of the output register collide");

endmodule

// ===== hw/rtl/dual_stack_shared_memory.sv =====
// Top level: two LIFO stacks in one shared array, with an APB capacity register.
// Results: a push or an empty pop loads its result word at accept; a successful
//   pop first registers the array read, then loads the output register.
// Flow: requests are taken while the output slot is free, but none after a
//   successful pop until its word loads (single array port, registered read).
// Reset: both stacks empty, capacity = min(256, MAX_DEPTH); array not cleared.
`timescale 1ns / 1ps

module dual_stack_shared_memory #(
    parameter int MAX_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    dssm_req_if.sink    req,
    dssm_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dssm_pkg::dssm_cmd_t        cmd;
    dssm_pkg::dssm_stat_t       stat;
    logic                       cfg_write;
    logic [dssm_pkg::CAP_W-1:0] capacity;

    // register 0 (capacity) at byte address 0; address 4 holds nothing
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? 32'(capacity) : 32'd0;

    dssm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .req_ready (req.ready),
        .cmd       (cmd)
    );

    dssm_datapath #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .operation    (req.operation),
        .push_value   (req.push_value),
        .cfg_write    (cfg_write),
        .cfg_data     (pwdata[dssm_pkg::CAP_W-1:0]),
        .capacity     (capacity),
        .rsp_ready    (rsp.ready),
        .rsp_valid    (rsp.valid),
        .popped_value (rsp.popped_value),
        .status       (rsp.status)
    );

endmodule
